// File: hdl/sacl_pkg.sv
// Package: shared types, constants and codes for the set-associative LRU cache core
`default_nettype none
package sacl_pkg;
    localparam int MAX_SET_BITS_DEF = 4;
    localparam int MAX_WAYS_DEF     = 8;
    localparam int AGE_WIDTH_DEF    = 32;

    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_STORE  = 2'd1;
    localparam logic [1:0] ACT_MODIFY = 2'd2;
    localparam logic [1:0] ACT_IFETCH = 2'd3;

    localparam logic [1:0] OUT_HIT   = 2'd0;
    localparam logic [1:0] OUT_FILL  = 2'd1;
    localparam logic [1:0] OUT_EVICT = 2'd2;

    localparam logic [1:0] REG_SET_BITS    = 2'd0;
    localparam logic [1:0] REG_WAYS        = 2'd1;
    localparam logic [1:0] REG_OFFSET_BITS = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic read;
        logic update;
        logic show;
    } cmd_t;

    typedef struct packed {
        logic again;
    } stat_t;
endpackage
`default_nettype wire

// File: hdl/sacl_ctrl.sv
// Controller: sequences read, update and result phases of each access
`default_nettype none
module sacl_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [1:0]    s_action,
    output logic               m_valid,
    input  wire logic          m_ready,
    input  wire sacl_pkg::stat_t stat,
    output sacl_pkg::cmd_t     cmd
);
    import sacl_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_action != ACT_IFETCH) state_next = ST_READ;
            end
            ST_READ:   state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_OUT;
            ST_OUT: begin
                if (m_ready) state_next = stat.again ? ST_READ : ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_READ:   cmd.read = 1'b1;
            ST_UPDATE: cmd.update = 1'b1;
            ST_OUT: begin
                m_valid  = 1'b1;
                cmd.show = m_ready;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// File: hdl/sacl_dp.sv
// Datapath: address split, set read, LRU update, counters and result word
`default_nettype none
module sacl_dp #(
    parameter int MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = sacl_pkg::MAX_WAYS_DEF,
    parameter int AGE_WIDTH    = sacl_pkg::AGE_WIDTH_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [4:0]    cfg_data,
    input  wire logic [1:0]    s_action,
    input  wire logic [31:0]   s_address,
    input  wire sacl_pkg::cmd_t cmd,
    output sacl_pkg::stat_t    stat,
    output logic [1:0]         m_outcome,
    output logic [3:0]         m_set_number,
    output logic [31:0]        m_tag_value,
    output logic [31:0]        m_hit_total,
    output logic [31:0]        m_miss_total,
    output logic [31:0]        m_evict_total,
    output logic               m_last
);
    import sacl_pkg::*;

    localparam int SETS = 1 << MAX_SET_BITS;
    localparam int SW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int CW   = $clog2(MAX_WAYS + 1);
    localparam logic [AGE_WIDTH-1:0] AGE_MAX = '1;

    logic [2:0]  set_bits_reg;
    logic [3:0]  ways_reg;
    logic [4:0]  offset_bits_reg;
    logic [31:0] hits_reg, misses_reg, evicts_reg;
    logic [SETS-1:0][MAX_WAYS-1:0] valid_reg;
    logic [31:0] addr_reg;
    logic        first_reg;

    logic [MAX_WAYS*32-1:0]        tag_mem [SETS];
    logic [MAX_WAYS*AGE_WIDTH-1:0] age_mem [SETS];
    logic [MAX_WAYS*32-1:0]        tag_rd_reg;
    logic [MAX_WAYS*AGE_WIDTH-1:0] age_rd_reg;
    logic [MAX_WAYS-1:0]           vld_rd_reg;

    logic [SW-1:0] set_idx_reg;
    logic [31:0]   tag_reg;
    logic [1:0]    outcome_reg;

    // address split
    logic [31:0] shifted;
    logic [2:0]  sb;
    logic [SW-1:0] set_idx;
    logic [31:0] tag;
    logic [CW-1:0] ways;

    always_comb begin
        shifted = addr_reg >> offset_bits_reg;
        sb = (32'(set_bits_reg) > 32'(MAX_SET_BITS)) ? 3'(MAX_SET_BITS) : set_bits_reg;
        set_idx = SW'(shifted & ((32'd1 << sb) - 32'd1));
        tag = shifted >> sb;
        if (ways_reg == 4'd0) ways = CW'(1);
        else if (32'(ways_reg) > 32'(MAX_WAYS)) ways = CW'(MAX_WAYS);
        else ways = CW'(ways_reg);
    end

    // update logic on registered set contents
    logic [MAX_WAYS-1:0]           in_use, hit_vec, free_vec;
    logic [AGE_WIDTH-1:0]          aged [MAX_WAYS];
    logic                          hit, has_free;
    logic [WW-1:0]                 hit_w, free_w, vic_w, sel_w;
    logic [AGE_WIDTH-1:0]          oldest;
    logic [MAX_WAYS*32-1:0]        tag_wr;
    logic [MAX_WAYS*AGE_WIDTH-1:0] age_wr;
    logic [MAX_WAYS-1:0]           vld_wr;
    logic [1:0]                    outcome;

    always_comb begin
        hit = 1'b0; has_free = 1'b0;
        hit_w = '0; free_w = '0; vic_w = '0;
        oldest = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            in_use[w] = (w < 32'(ways));
            aged[w] = age_rd_reg[w*AGE_WIDTH +: AGE_WIDTH];
            if (in_use[w] && vld_rd_reg[w] && aged[w] != AGE_MAX)
                aged[w] = aged[w] + 1'b1;
            hit_vec[w]  = in_use[w] && vld_rd_reg[w] && tag_rd_reg[w*32 +: 32] == tag_reg;
            free_vec[w] = in_use[w] && !vld_rd_reg[w];
        end
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w])  begin hit = 1'b1; hit_w = WW'(w); end
            if (free_vec[w]) begin has_free = 1'b1; free_w = WW'(w); end
        end
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (in_use[w] && (w == 0 || aged[w] > oldest)) begin
                oldest = aged[w];
                vic_w  = WW'(w);
            end
        end
        if (hit) begin
            outcome = OUT_HIT; sel_w = hit_w;
        end else if (has_free) begin
            outcome = OUT_FILL; sel_w = free_w;
        end else begin
            outcome = OUT_EVICT; sel_w = vic_w;
        end
        tag_wr = tag_rd_reg;
        vld_wr = vld_rd_reg;
        for (int w = 0; w < MAX_WAYS; w++) begin
            age_wr[w*AGE_WIDTH +: AGE_WIDTH] = aged[w];
        end
        tag_wr[32*sel_w +: 32] = tag_reg;
        age_wr[AGE_WIDTH*sel_w +: AGE_WIDTH] = '0;
        vld_wr[sel_w] = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_bits_reg    <= '0;
            ways_reg        <= 4'd1;
            offset_bits_reg <= '0;
            hits_reg        <= '0;
            misses_reg      <= '0;
            evicts_reg      <= '0;
            valid_reg       <= '0;
            first_reg       <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_SET_BITS:    set_bits_reg    <= cfg_data[2:0];
                    REG_WAYS:        ways_reg        <= cfg_data[3:0];
                    REG_OFFSET_BITS: offset_bits_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.load) first_reg <= (s_action == ACT_MODIFY);
            if (cmd.show) first_reg <= 1'b0;
            if (cmd.update) begin
                valid_reg[set_idx_reg] <= vld_wr;
                if (outcome == OUT_HIT) begin
                    if (hits_reg != '1) hits_reg <= hits_reg + 1'b1;
                end else if (misses_reg != '1) begin
                    misses_reg <= misses_reg + 1'b1;
                end
                if (outcome == OUT_EVICT && evicts_reg != '1)
                    evicts_reg <= evicts_reg + 1'b1;
            end
        end
    end

    // age of an invalid line is never used: a fill writes zero before it counts
    always_ff @(posedge aclk) begin
        if (cmd.load) addr_reg <= s_address;
        if (cmd.read) begin
            set_idx_reg <= set_idx;
            tag_reg     <= tag;
            tag_rd_reg  <= tag_mem[set_idx];
            age_rd_reg  <= age_mem[set_idx];
            vld_rd_reg  <= valid_reg[set_idx];
        end
        if (cmd.update) begin
            tag_mem[set_idx_reg] <= tag_wr;
            age_mem[set_idx_reg] <= age_wr;
            outcome_reg          <= outcome;
        end
    end

    assign stat.again    = first_reg;
    assign m_outcome     = outcome_reg;
    assign m_set_number  = 4'(set_idx_reg & SW'((32'd1 << sb) - 32'd1));
    assign m_tag_value   = tag_reg;
    assign m_hit_total   = hits_reg;
    assign m_miss_total  = misses_reg;
    assign m_evict_total = evicts_reg;
    assign m_last        = !first_reg;
endmodule
`default_nettype wire

// File: hdl/set_assoc_cache_lru_sim_core.sv
// Top level: set-associative tag cache with LRU replacement and hit/miss counters
// Usage:
//  Input channel s_valid/s_ready carries one word: s_action and s_address.
//  Load and store make one access and one result; modify makes two accesses
//  and two results (m_last low then high); an instruction fetch is dropped
//  with no result.
//  Each access reads the whole set in the READ state, updates tags, ages and
//  counters in UPDATE, and presents the result in OUT; a modify passes through
//  READ, UPDATE and OUT once for each of its results. After the last result
//  is accepted the controller returns to IDLE, where the next word is taken.
//  The set read-modify-write through the per-set tag and age store sets this
//  sequence.
//  The result holds on the m_ ports while m_ready is low; no new word is
//  taken until the last result of the current one is accepted.
//  Configuration must be written through cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
//  Reset (aresetn low, synchronous) clears valid bits, counters and control
//  and restores set_bits 0, ways_in_use 1, offset_bits 0; no clearing pass.
`default_nettype none
module set_assoc_cache_lru_sim_core #(
    parameter int MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = sacl_pkg::MAX_WAYS_DEF,
    parameter int AGE_WIDTH    = sacl_pkg::AGE_WIDTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [4:0]  cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_action,
    input  wire logic [31:0] s_address,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_outcome,
    output logic [3:0]       m_set_number,
    output logic [31:0]      m_tag_value,
    output logic [31:0]      m_hit_total,
    output logic [31:0]      m_miss_total,
    output logic [31:0]      m_evict_total,
    output logic             m_last
);
    import sacl_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    sacl_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_action,
        .m_valid, .m_ready, .stat, .cmd
    );

    sacl_dp #(
        .MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS), .AGE_WIDTH(AGE_WIDTH)
    ) u_dp (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_data, .s_action, .s_address,
        .cmd, .stat, .m_outcome, .m_set_number, .m_tag_value, .m_hit_total,
        .m_miss_total, .m_evict_total, .m_last
    );

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input taken while result pending");
    a_outcome_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_outcome != 2'd3)) else $error("bad outcome code");
    a_hit_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=> ##1 !m_valid)
        else $error("second access of modify too early");
`endif
endmodule
`default_nettype wire
